// ===== src/msv_pkg.sv =====
// Shared types and constants of the motion safety supervisor.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package msv_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIMER_W    = 32;
  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned MASK_W     = 4;

  // enable_mask bits
  localparam int unsigned EN_TERMINAL   = 0;
  localparam int unsigned EN_TRACKING   = 1;
  localparam int unsigned EN_PROJECTION = 2;
  localparam int unsigned EN_SPIN       = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE_MASK       = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TERMINAL_OMEGA    = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TERMINAL_TIME     = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PROJECTION_DIST   = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PROJECTION_TIME   = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TRACKING_OMEGA    = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOW_SPEED        = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_TRACKING_SPIN_TIME = 4'd7;

  typedef enum logic [1:0] {
    INTV_NONE       = 2'd0,
    INTV_TERMINAL   = 2'd1,
    INTV_PROJECTION = 2'd2,
    INTV_SPIN       = 2'd3
  } msv_intv_e;

  typedef struct packed {
    logic [MASK_W-1:0]  enable_mask;
    logic [LIMIT_W-1:0] terminal_omega_limit;
    logic [TIMER_W-1:0] terminal_spin_time_limit;
    logic [DIST_W-1:0]  projection_distance_limit;
    logic [TIMER_W-1:0] projection_time_limit;
    logic [LIMIT_W-1:0] tracking_omega_limit;
    logic [LIMIT_W-1:0] slow_speed_limit;
    logic [TIMER_W-1:0] tracking_spin_time_limit;
  } msv_cfg_t;

  typedef struct packed {
    logic                     cmd_accepted;
    logic                     in_terminal_phase;
    logic                     goal_hit;
    logic                     status_goal_reached;
    logic signed [RATE_W-1:0] robot_omega;
    logic signed [RATE_W-1:0] robot_speed;
    logic signed [RATE_W-1:0] cmd_angular;
    logic                     guard_ok;
    logic [DIST_W-1:0]        guarded_distance;
    logic                     raw_ok;
    logic [DIST_W-1:0]        raw_distance;
    logic [PERIOD_W-1:0]      period_us;
  } msv_in_t;

  typedef struct packed {
    logic               blocked;
    logic               term_blocked;
    logic               tracking_blocked;
    logic               accepted_out;
    msv_intv_e          intervention;
    logic [TIMER_W-1:0] terminal_time;
    logic [TIMER_W-1:0] projection_time;
    logic [TIMER_W-1:0] tracking_spin_time;
    logic               terminal_latch_out;
    logic               projection_latch_out;
    logic               spin_latch_out;
  } msv_out_t;

  typedef struct packed {
    logic [TIMER_W-1:0] terminal_timer;
    logic               terminal_latch;
    logic [TIMER_W-1:0] projection_timer;
    logic               projection_latch;
    logic [TIMER_W-1:0] spin_timer;
    logic               spin_latch;
  } msv_state_t;

endpackage
`default_nettype wire

// ===== src/msv_ifs.sv =====
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on msv_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface msv_in_if;
  logic           valid;
  logic           ready;
  msv_pkg::msv_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface msv_out_if;
  logic            valid;
  logic            ready;
  msv_pkg::msv_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface msv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [msv_pkg::CFG_ADDR_W-1:0]   index;
  logic [msv_pkg::CFG_DATA_W-1:0]   wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== src/motion_safety_supervisor_top.sv =====
// Top level of the motion safety supervisor: input register, state, result register.
// Depends on msv_pkg, msv_ifs, msv_cfg_regs and msv_step_logic.
`timescale 1ns / 1ps
`default_nettype none
// One input item per clock is accepted while results are taken, and it gives
// exactly one result item: the item is captured in an input register, and the
// combinational update of the three saturating timers and their latches runs
// between that register and the result register, which loads with the state
// once the result slot frees. The throughput of one item per cycle is set by
// that timer/latch feedback loop. While a result waits, one more item is taken
// into the input register and then the input stalls until the result transfers.
// Configuration writes are taken every cycle and are meant only while the block
// is idle; the valid flags, state and config reset to 0, the data registers do not.
module motion_safety_supervisor_top #(
  parameter int unsigned NOMINAL_PERIOD_US = 50000
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  msv_in_if.sink     item_i,
  msv_out_if.source  result_o,
  msv_cfg_if.sink    cfg_i
);

  msv_pkg::msv_cfg_t   cfg;
  msv_pkg::msv_state_t state_q, state_d;
  msv_pkg::msv_in_t    item_q;
  msv_pkg::msv_out_t   res_q, res_d;
  logic                item_valid_q, res_valid_q;
  logic                advance, take;

  assign cfg_i.ready = 1'b1;

  msv_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  msv_step_logic #(
    .NOMINAL_PERIOD_US (NOMINAL_PERIOD_US)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // move the held item into the result register when that slot frees
  assign advance      = item_valid_q && (!res_valid_q || result_o.ready);
  assign item_i.ready = !item_valid_q || advance;
  assign take         = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      if (take) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i.data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule
`default_nettype wire

// ===== src/msv_cfg_regs.sv =====
// Configuration register bank of the motion safety supervisor.
// Depends on msv_pkg; written through a valid/ready write channel.
`timescale 1ns / 1ps
`default_nettype none
module msv_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [msv_pkg::CFG_ADDR_W-1:0] wr_index_i,
  input  wire logic [msv_pkg::CFG_DATA_W-1:0] wr_data_i,
  output msv_pkg::msv_cfg_t                   cfg_o
);

  msv_pkg::msv_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        msv_pkg::REG_ENABLE_MASK:
          cfg_d.enable_mask = wr_data_i[msv_pkg::MASK_W-1:0];
        msv_pkg::REG_TERMINAL_OMEGA:
          cfg_d.terminal_omega_limit = wr_data_i[msv_pkg::LIMIT_W-1:0];
        msv_pkg::REG_TERMINAL_TIME:
          cfg_d.terminal_spin_time_limit = wr_data_i[msv_pkg::TIMER_W-1:0];
        msv_pkg::REG_PROJECTION_DIST:
          cfg_d.projection_distance_limit = wr_data_i[msv_pkg::DIST_W-1:0];
        msv_pkg::REG_PROJECTION_TIME:
          cfg_d.projection_time_limit = wr_data_i[msv_pkg::TIMER_W-1:0];
        msv_pkg::REG_TRACKING_OMEGA:
          cfg_d.tracking_omega_limit = wr_data_i[msv_pkg::LIMIT_W-1:0];
        msv_pkg::REG_SLOW_SPEED:
          cfg_d.slow_speed_limit = wr_data_i[msv_pkg::LIMIT_W-1:0];
        msv_pkg::REG_TRACKING_SPIN_TIME:
          cfg_d.tracking_spin_time_limit = wr_data_i[msv_pkg::TIMER_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== src/msv_step_logic.sv =====
// Combinational update of one control cycle: timers, latches and result.
// Depends on msv_pkg for the config, state, item and result types.
`timescale 1ns / 1ps
`default_nettype none
module msv_step_logic #(
  parameter int unsigned NOMINAL_PERIOD_US = 50000
) (
  input  wire msv_pkg::msv_cfg_t   cfg_i,
  input  wire msv_pkg::msv_state_t state_i,
  input  wire msv_pkg::msv_in_t    item_i,
  output msv_pkg::msv_state_t      state_o,
  output msv_pkg::msv_out_t        result_o
);

  localparam logic [msv_pkg::PERIOD_W-1:0] NominalPeriod =
    msv_pkg::PERIOD_W'(NOMINAL_PERIOD_US);

  function automatic logic [msv_pkg::MAG_W-1:0] mag(
    input logic signed [msv_pkg::RATE_W-1:0] v
  );
    logic [msv_pkg::MAG_W-1:0] ext;
    ext = {v[msv_pkg::RATE_W-1], v};
    return v[msv_pkg::RATE_W-1] ? (~ext + 1'b1) : ext;
  endfunction

  function automatic logic [msv_pkg::TIMER_W-1:0] sat_add(
    input logic [msv_pkg::TIMER_W-1:0]  a,
    input logic [msv_pkg::PERIOD_W-1:0] b
  );
    logic [msv_pkg::TIMER_W:0] s;
    s = {1'b0, a} + {{(msv_pkg::TIMER_W - msv_pkg::PERIOD_W + 1){1'b0}}, b};
    return s[msv_pkg::TIMER_W] ? '1 : s[msv_pkg::TIMER_W-1:0];
  endfunction

  logic [msv_pkg::MAG_W-1:0]    omega, speed, ang;
  logic [msv_pkg::PERIOD_W-1:0] period;
  logic [msv_pkg::MASK_W-1:0]   en;
  logic                         acc, reached;
  logic                         term_clear, tb;
  logic [msv_pkg::TIMER_W-1:0]  term_sum;
  logic                         track_clear;
  logic [msv_pkg::DIST_W-1:0]   sel_dist;
  logic                         unsafe, spinning;
  logic [msv_pkg::TIMER_W-1:0]  proj_next, spin_next;
  msv_pkg::msv_intv_e           trk;
  logic                         trk_blocked, blocked;

  always_comb begin
    omega   = mag(item_i.robot_omega);
    speed   = mag(item_i.robot_speed);
    ang     = mag(item_i.cmd_angular);
    en      = cfg_i.enable_mask;
    acc     = item_i.cmd_accepted;
    reached = item_i.goal_hit;
    // a period of at most one microsecond falls back to the nominal one
    period  = (item_i.period_us <= msv_pkg::PERIOD_W'(1)) ? NominalPeriod
                                                          : item_i.period_us;

    state_o = state_i;
    tb      = 1'b0;
    trk     = msv_pkg::INTV_NONE;

    // terminal spin check
    term_clear = !en[msv_pkg::EN_TERMINAL] || !acc || !item_i.in_terminal_phase ||
                 reached ||
                 !((omega > msv_pkg::MAG_W'(cfg_i.terminal_omega_limit)) ||
                   (ang > msv_pkg::MAG_W'(cfg_i.terminal_omega_limit)));
    term_sum = sat_add(state_i.terminal_timer, period);
    if (term_clear) begin
      state_o.terminal_timer = '0;
      state_o.terminal_latch = 1'b0;
    end else begin
      state_o.terminal_timer = term_sum;
      if (state_i.terminal_latch || (term_sum >= cfg_i.terminal_spin_time_limit)) begin
        state_o.terminal_latch = 1'b1;
        tb = 1'b1;
      end
    end

    // tracking checks
    sel_dist = item_i.guard_ok ? item_i.guarded_distance : item_i.raw_distance;
    unsafe   = en[msv_pkg::EN_PROJECTION] && (item_i.guard_ok || item_i.raw_ok) &&
               (cfg_i.projection_distance_limit != '0) &&
               (sel_dist > cfg_i.projection_distance_limit);
    spinning = en[msv_pkg::EN_SPIN] && !item_i.in_terminal_phase &&
               (speed <= msv_pkg::MAG_W'(cfg_i.slow_speed_limit)) &&
               ((omega > msv_pkg::MAG_W'(cfg_i.tracking_omega_limit)) ||
                (ang > msv_pkg::MAG_W'(cfg_i.tracking_omega_limit)));
    proj_next = unsafe ? sat_add(state_i.projection_timer, period) : '0;
    spin_next = spinning ? sat_add(state_i.spin_timer, period) : '0;

    track_clear = !en[msv_pkg::EN_TRACKING] || reached ||
                  (item_i.status_goal_reached && !tb);
    if (track_clear) begin
      state_o.projection_timer = '0;
      state_o.projection_latch = 1'b0;
      state_o.spin_timer       = '0;
      state_o.spin_latch       = 1'b0;
    end else if (state_i.projection_latch) begin
      trk = msv_pkg::INTV_PROJECTION;
    end else if (state_i.spin_latch) begin
      trk = msv_pkg::INTV_SPIN;
    end else if (acc && !tb) begin
      state_o.projection_timer = proj_next;
      state_o.spin_timer       = spin_next;
      // projection wins when both limits are reached together
      if (en[msv_pkg::EN_PROJECTION] && (cfg_i.projection_time_limit != '0) &&
          (proj_next >= cfg_i.projection_time_limit)) begin
        state_o.projection_latch = 1'b1;
        trk = msv_pkg::INTV_PROJECTION;
      end else if (en[msv_pkg::EN_SPIN] && (cfg_i.tracking_spin_time_limit != '0) &&
                   (spin_next >= cfg_i.tracking_spin_time_limit)) begin
        state_o.spin_latch = 1'b1;
        trk = msv_pkg::INTV_SPIN;
      end
    end

    trk_blocked = (trk != msv_pkg::INTV_NONE);
    blocked     = tb || trk_blocked;

    result_o.blocked              = blocked;
    result_o.term_blocked         = tb;
    result_o.tracking_blocked     = trk_blocked;
    result_o.accepted_out         = acc && !blocked;
    result_o.intervention         = trk_blocked ? trk :
                                    (tb ? msv_pkg::INTV_TERMINAL : msv_pkg::INTV_NONE);
    result_o.terminal_time        = state_o.terminal_timer;
    result_o.projection_time      = state_o.projection_timer;
    result_o.tracking_spin_time   = state_o.spin_timer;
    result_o.terminal_latch_out   = state_o.terminal_latch;
    result_o.projection_latch_out = state_o.projection_latch;
    result_o.spin_latch_out       = state_o.spin_latch;
  end

endmodule
`default_nettype wire

// ===== bench/motion_safety_supervisor_top_tb.sv =====
// Self-checking bench for motion_safety_supervisor_top: directed control cycles and
// random scenario bursts under several limit settings, with long result stalls.
// Depends on msv_pkg and the channel interfaces in msv_ifs.
`timescale 1ns / 1ps
module motion_safety_supervisor_top_tb;

  localparam int unsigned NOMINAL_PERIOD_US = 50000;
  localparam int unsigned HOLD_OFF_CYCLES   = 80;
  localparam int unsigned PHASES            = 10;
  localparam int unsigned PHASE_ITEMS       = 123;
  localparam longint unsigned TIMEOUT_NS    = 64'd1_000_000;
  // index outside the register map, written once to check that it is ignored
  localparam logic [msv_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 4'hF;

  typedef enum int {
    SCN_NOISE,
    SCN_TERMINAL,
    SCN_PROJECTION,
    SCN_SPIN,
    SCN_GOAL
  } scenario_e;

  // Tracks limits, timers and latches; holds the results still owed by the block.
  class supervisor_scoreboard;
    msv_pkg::msv_cfg_t   cfg;
    msv_pkg::msv_state_t st;
    msv_pkg::msv_out_t   expected_q[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned intv_count[4];
    int unsigned saturated_results;

    function new();
      cfg = '0;
      st  = '0;
    endfunction

    function void set_reg(logic [msv_pkg::CFG_ADDR_W-1:0] idx,
                          logic [msv_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        msv_pkg::REG_ENABLE_MASK:
          cfg.enable_mask = val[msv_pkg::MASK_W-1:0];
        msv_pkg::REG_TERMINAL_OMEGA:
          cfg.terminal_omega_limit = val[msv_pkg::LIMIT_W-1:0];
        msv_pkg::REG_TERMINAL_TIME:
          cfg.terminal_spin_time_limit = val;
        msv_pkg::REG_PROJECTION_DIST:
          cfg.projection_distance_limit = val[msv_pkg::DIST_W-1:0];
        msv_pkg::REG_PROJECTION_TIME:
          cfg.projection_time_limit = val;
        msv_pkg::REG_TRACKING_OMEGA:
          cfg.tracking_omega_limit = val[msv_pkg::LIMIT_W-1:0];
        msv_pkg::REG_SLOW_SPEED:
          cfg.slow_speed_limit = val[msv_pkg::LIMIT_W-1:0];
        msv_pkg::REG_TRACKING_SPIN_TIME:
          cfg.tracking_spin_time_limit = val;
        default: ;
      endcase
    endfunction

    function logic [msv_pkg::MAG_W-1:0] rate_mag(logic signed [msv_pkg::RATE_W-1:0] v);
      return v[msv_pkg::RATE_W-1] ? msv_pkg::MAG_W'(17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

    function logic [msv_pkg::TIMER_W-1:0] sat_add(logic [msv_pkg::TIMER_W-1:0] a,
                                                  logic [msv_pkg::TIMER_W-1:0] b);
      logic [msv_pkg::TIMER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[msv_pkg::TIMER_W] ? '1 : s[msv_pkg::TIMER_W-1:0];
    endfunction

    function void clear_tracking();
      st.projection_timer = '0;
      st.projection_latch = 1'b0;
      st.spin_timer       = '0;
      st.spin_latch       = 1'b0;
    endfunction

    // One control cycle: update timers and latches, return the verdict.
    function msv_pkg::msv_out_t advance_cycle(msv_pkg::msv_in_t it);
      msv_pkg::msv_out_t           r;
      logic [msv_pkg::MAG_W-1:0]   w_rate, s_mag, c_rate;
      logic [msv_pkg::TIMER_W-1:0] dt;
      logic [msv_pkg::DIST_W-1:0]  range_mm;
      logic                        tb, pvalid, unsafe, spinning;
      msv_pkg::msv_intv_e          trk;
      r      = '0;
      tb     = 1'b0;
      trk    = msv_pkg::INTV_NONE;
      w_rate = rate_mag(it.robot_omega);
      s_mag  = rate_mag(it.robot_speed);
      c_rate = rate_mag(it.cmd_angular);
      dt     = (it.period_us <= 1) ? msv_pkg::TIMER_W'(NOMINAL_PERIOD_US)
                                   : msv_pkg::TIMER_W'(it.period_us);

      if (!cfg.enable_mask[msv_pkg::EN_TERMINAL] || !it.cmd_accepted ||
          !it.in_terminal_phase || it.goal_hit ||
          !(w_rate > cfg.terminal_omega_limit || c_rate > cfg.terminal_omega_limit)) begin
        st.terminal_timer = '0;
        st.terminal_latch = 1'b0;
      end else begin
        st.terminal_timer = sat_add(st.terminal_timer, dt);
        if (st.terminal_latch || st.terminal_timer >= cfg.terminal_spin_time_limit) begin
          st.terminal_latch = 1'b1;
          tb = 1'b1;
        end
      end

      // a terminal block hides acceptance and goal status from the tracking stage
      if (!cfg.enable_mask[msv_pkg::EN_TRACKING] || it.goal_hit ||
          (it.status_goal_reached && !tb)) begin
        clear_tracking();
      end else if (st.projection_latch) begin
        trk = msv_pkg::INTV_PROJECTION;
      end else if (st.spin_latch) begin
        trk = msv_pkg::INTV_SPIN;
      end else if (it.cmd_accepted && !tb) begin
        pvalid   = it.guard_ok || it.raw_ok;
        range_mm = it.guard_ok ? it.guarded_distance : it.raw_distance;
        unsafe   = cfg.enable_mask[msv_pkg::EN_PROJECTION] && pvalid &&
                   cfg.projection_distance_limit != 0 &&
                   range_mm > cfg.projection_distance_limit;
        spinning = cfg.enable_mask[msv_pkg::EN_SPIN] && !it.in_terminal_phase &&
                   s_mag <= cfg.slow_speed_limit &&
                   (w_rate > cfg.tracking_omega_limit || c_rate > cfg.tracking_omega_limit);
        st.projection_timer = unsafe ? sat_add(st.projection_timer, dt) : '0;
        st.spin_timer       = spinning ? sat_add(st.spin_timer, dt) : '0;
        // projection takes priority when both reach their limit together
        if (cfg.enable_mask[msv_pkg::EN_PROJECTION] && cfg.projection_time_limit != 0 &&
            st.projection_timer >= cfg.projection_time_limit) begin
          st.projection_latch = 1'b1;
          trk = msv_pkg::INTV_PROJECTION;
        end else if (cfg.enable_mask[msv_pkg::EN_SPIN] && cfg.tracking_spin_time_limit != 0 &&
                     st.spin_timer >= cfg.tracking_spin_time_limit) begin
          st.spin_latch = 1'b1;
          trk = msv_pkg::INTV_SPIN;
        end
      end

      r.term_blocked         = tb;
      r.tracking_blocked     = (trk != msv_pkg::INTV_NONE);
      r.blocked              = tb || (trk != msv_pkg::INTV_NONE);
      r.accepted_out         = it.cmd_accepted && !r.blocked;
      r.intervention         = (trk != msv_pkg::INTV_NONE) ? trk :
                               (tb ? msv_pkg::INTV_TERMINAL : msv_pkg::INTV_NONE);
      r.terminal_time        = st.terminal_timer;
      r.projection_time      = st.projection_timer;
      r.tracking_spin_time   = st.spin_timer;
      r.terminal_latch_out   = st.terminal_latch;
      r.projection_latch_out = st.projection_latch;
      r.spin_latch_out       = st.spin_latch;
      return r;
    endfunction

    function void note_item(msv_pkg::msv_in_t it);
      expected_q.push_back(advance_cycle(it));
    endfunction

    function void compare(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d %s: expected %0h, got %0h", results_checked, field,
                   want_v, got_v);
      end
    endfunction

    function void check_result(msv_pkg::msv_out_t got);
      msv_pkg::msv_out_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing pending", results_checked);
        return;
      end
      want = expected_q.pop_front();
      intv_count[want.intervention]++;
      if (&want.terminal_time || &want.projection_time || &want.tracking_spin_time)
        saturated_results++;
      compare("blocked", 32'(want.blocked), 32'(got.blocked));
      compare("term_blocked", 32'(want.term_blocked), 32'(got.term_blocked));
      compare("tracking_blocked", 32'(want.tracking_blocked), 32'(got.tracking_blocked));
      compare("accepted_out", 32'(want.accepted_out), 32'(got.accepted_out));
      compare("intervention", 32'(want.intervention), 32'(got.intervention));
      compare("terminal_time", want.terminal_time, got.terminal_time);
      compare("projection_time", want.projection_time, got.projection_time);
      compare("tracking_spin_time", want.tracking_spin_time, got.tracking_spin_time);
      compare("terminal_latch_out", 32'(want.terminal_latch_out),
              32'(got.terminal_latch_out));
      compare("projection_latch_out", 32'(want.projection_latch_out),
              32'(got.projection_latch_out));
      compare("spin_latch_out", 32'(want.spin_latch_out), 32'(got.spin_latch_out));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  msv_in_if  item_if ();
  msv_out_if res_if ();
  msv_cfg_if cfg_if ();

  supervisor_scoreboard board = new();

  bit          no_idle;
  bit          hold_off_req;
  bit          offer_held;
  int unsigned send_gap;
  int unsigned items_sent;
  int unsigned config_sets;
  int unsigned hold_offs;

  motion_safety_supervisor_top #(
    .NOMINAL_PERIOD_US(NOMINAL_PERIOD_US)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note inputs before results so a same-edge transfer is always predicted first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (item_if.valid && item_if.ready) board.note_item(item_if.data);
      if (res_if.valid && res_if.ready) board.check_result(res_if.data);
    end
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait();
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
        hold_offs++;
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("run timed out after %0d ns with %0d results pending", TIMEOUT_NS,
             board.expected_q.size());
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input msv_pkg::msv_in_t it);
    repeat (send_gap) @(posedge clk);
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    offer_held = 1'b1;
    do @(posedge clk); while (!item_if.ready);
    items_sent++;
    // keep valid high across a zero gap rather than dropping and raising it
    send_gap = draw_wait();
    if (send_gap != 0) begin
      item_if.valid <= 1'b0;
      offer_held = 1'b0;
    end
  endtask

  task automatic sender_park();
    if (offer_held) begin
      item_if.valid <= 1'b0;
      offer_held = 1'b0;
    end
  endtask

  task automatic send_fields(input logic acc, input logic term, input logic reached,
                             input logic status,
                             input logic signed [msv_pkg::RATE_W-1:0] omega,
                             input logic signed [msv_pkg::RATE_W-1:0] speed,
                             input logic signed [msv_pkg::RATE_W-1:0] ang,
                             input logic gv, input logic [msv_pkg::DIST_W-1:0] gd,
                             input logic rv, input logic [msv_pkg::DIST_W-1:0] rd,
                             input logic [msv_pkg::PERIOD_W-1:0] period);
    msv_pkg::msv_in_t it;
    it.cmd_accepted        = acc;
    it.in_terminal_phase   = term;
    it.goal_hit            = reached;
    it.status_goal_reached = status;
    it.robot_omega         = omega;
    it.robot_speed         = speed;
    it.cmd_angular         = ang;
    it.guard_ok            = gv;
    it.guarded_distance    = gd;
    it.raw_ok              = rv;
    it.raw_distance        = rd;
    it.period_us           = period;
    send_item(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (board.expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [msv_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [msv_pkg::CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_reg(idx, val);
  endtask

  // Only called with the block drained; valid stays high across the writes.
  task automatic load_limits(input msv_pkg::msv_cfg_t c);
    write_reg(msv_pkg::REG_ENABLE_MASK, 32'(c.enable_mask));
    write_reg(msv_pkg::REG_TERMINAL_OMEGA, 32'(c.terminal_omega_limit));
    write_reg(msv_pkg::REG_TERMINAL_TIME, c.terminal_spin_time_limit);
    write_reg(msv_pkg::REG_PROJECTION_DIST, 32'(c.projection_distance_limit));
    write_reg(msv_pkg::REG_PROJECTION_TIME, c.projection_time_limit);
    write_reg(msv_pkg::REG_TRACKING_OMEGA, 32'(c.tracking_omega_limit));
    write_reg(msv_pkg::REG_SLOW_SPEED, 32'(c.slow_speed_limit));
    write_reg(msv_pkg::REG_TRACKING_SPIN_TIME, c.tracking_spin_time_limit);
    cfg_if.valid <= 1'b0;
    config_sets++;
  endtask

  function automatic logic [msv_pkg::TIMER_W-1:0] pick_time();
    return ($urandom_range(0, 3) == 0) ? '0 : msv_pkg::TIMER_W'($urandom_range(1, 600));
  endfunction

  function automatic msv_pkg::msv_cfg_t rand_config(bit wide);
    msv_pkg::msv_cfg_t c;
    c.enable_mask               = ($urandom_range(0, 1) != 0) ? 4'hF
                                                              : msv_pkg::MASK_W'($urandom());
    c.terminal_omega_limit      = wide ? msv_pkg::LIMIT_W'($urandom())
                                       : msv_pkg::LIMIT_W'($urandom_range(0, 2000));
    c.terminal_spin_time_limit  = wide ? $urandom() : pick_time();
    c.projection_distance_limit = wide ? msv_pkg::DIST_W'($urandom())
                                       : msv_pkg::DIST_W'($urandom_range(0, 5000));
    c.projection_time_limit     = wide ? $urandom() : pick_time();
    c.tracking_omega_limit      = wide ? msv_pkg::LIMIT_W'($urandom())
                                       : msv_pkg::LIMIT_W'($urandom_range(0, 2000));
    c.slow_speed_limit          = wide ? msv_pkg::LIMIT_W'($urandom())
                                       : msv_pkg::LIMIT_W'($urandom_range(0, 3000));
    c.tracking_spin_time_limit  = wide ? $urandom() : pick_time();
    return c;
  endfunction

  function automatic logic [msv_pkg::PERIOD_W-1:0] draw_period();
    case ($urandom_range(0, 9))
      0:       return msv_pkg::PERIOD_W'($urandom_range(0, 1));
      1:       return msv_pkg::PERIOD_W'($urandom());
      2:       return msv_pkg::PERIOD_W'(1_000_000);
      default: return msv_pkg::PERIOD_W'($urandom_range(2, 300));
    endcase
  endfunction

  // Rate whose magnitude exceeds lim; only the most negative code clears 32767.
  function automatic logic signed [msv_pkg::RATE_W-1:0] rate_above(int unsigned lim);
    int unsigned m;
    m = $urandom_range(lim + 1, 32768);
    if (m == 32768) return 16'sh8000;
    return ($urandom_range(0, 1) != 0) ? msv_pkg::RATE_W'(m) : msv_pkg::RATE_W'(-int'(m));
  endfunction

  function automatic logic signed [msv_pkg::RATE_W-1:0] rate_upto(int unsigned lim);
    int unsigned m;
    m = $urandom_range(0, lim);
    return ($urandom_range(0, 1) != 0) ? msv_pkg::RATE_W'(m) : msv_pkg::RATE_W'(-int'(m));
  endfunction

  function automatic logic [msv_pkg::DIST_W-1:0] dist_above(int unsigned lim);
    return (lim >= 65535) ? 16'hFFFF : msv_pkg::DIST_W'($urandom_range(lim + 1, 65535));
  endfunction

  function automatic bit one_in(int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic scenario_e pick_scenario();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return SCN_NOISE;
    if (r < 45) return SCN_TERMINAL;
    if (r < 65) return SCN_PROJECTION;
    if (r < 85) return SCN_SPIN;
    return SCN_GOAL;
  endfunction

  // Random item shaped toward one check, with the odd field left broken.
  function automatic msv_pkg::msv_in_t make_item(scenario_e sc);
    msv_pkg::msv_in_t it;
    logic [127:0]     raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it  = raw[$bits(msv_pkg::msv_in_t)-1:0];
    it.period_us = draw_period();
    case (sc)
      SCN_TERMINAL: begin
        it.cmd_accepted        = !one_in(16);
        it.in_terminal_phase   = !one_in(16);
        it.goal_hit            = one_in(16);
        it.status_goal_reached = one_in(4);
        if ($urandom_range(0, 1) != 0)
          it.robot_omega = rate_above(board.cfg.terminal_omega_limit);
        else
          it.cmd_angular = rate_above(board.cfg.terminal_omega_limit);
      end
      SCN_PROJECTION: begin
        it.cmd_accepted        = !one_in(16);
        it.in_terminal_phase   = one_in(4);
        it.goal_hit            = one_in(16);
        it.status_goal_reached = one_in(8);
        it.robot_omega         = rate_upto(board.cfg.tracking_omega_limit);
        it.cmd_angular         = rate_upto(board.cfg.tracking_omega_limit);
        if (one_in(2)) begin
          it.guard_ok         = 1'b1;
          it.guarded_distance = dist_above(board.cfg.projection_distance_limit);
        end else begin
          it.guard_ok     = one_in(6);
          it.raw_ok       = 1'b1;
          it.raw_distance = dist_above(board.cfg.projection_distance_limit);
        end
      end
      SCN_SPIN: begin
        it.cmd_accepted        = !one_in(16);
        it.in_terminal_phase   = one_in(16);
        it.goal_hit            = one_in(16);
        it.status_goal_reached = one_in(8);
        it.robot_speed         = one_in(8) ? it.robot_speed
                                           : rate_upto(board.cfg.slow_speed_limit);
        if ($urandom_range(0, 1) != 0)
          it.robot_omega = rate_above(board.cfg.tracking_omega_limit);
        else
          it.cmd_angular = rate_above(board.cfg.tracking_omega_limit);
      end
      SCN_GOAL: begin
        if ($urandom_range(0, 1) != 0) it.goal_hit = 1'b1;
        else it.status_goal_reached = 1'b1;
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin : stimulus
    msv_pkg::msv_cfg_t c;
    scenario_e         sc;
    int unsigned       n, len;

    rst_n         <= 1'b0;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.wdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cycles under known limits
    c = '{enable_mask: 4'hF, terminal_omega_limit: 15'd100, terminal_spin_time_limit: 32'd120,
          projection_distance_limit: 16'd1000, projection_time_limit: 32'd200,
          tracking_omega_limit: 15'd100, slow_speed_limit: 15'd50,
          tracking_spin_time_limit: 32'd150};
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    load_limits(c);
    // nothing asserted, zero period falls back to nominal
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // terminal spin at the most negative rate, period of one, latches at once
    send_fields(1, 1, 0, 0, 16'sh8000, 0, 0, 0, 0, 0, 0, 1);
    send_fields(1, 1, 0, 0, 0, 0, 300, 0, 0, 0, 0, 2);
    // spin stops: terminal timer and latch drop
    send_fields(1, 1, 0, 0, 50, 0, -50, 0, 0, 0, 0, 7);
    send_fields(1, 1, 1, 0, 16'sh8000, 0, 0, 0, 0, 0, 0, 3);
    // projection via guarded then raw distance
    send_fields(1, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF, 0, 0, 100);
    send_fields(1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2000, 100);
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5);
    send_fields(1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 5);
    // tracking spin in place
    send_fields(1, 0, 0, 0, 0, -50, 16'sh8000, 0, 0, 0, 0, 100);
    send_fields(1, 0, 0, 0, 0, -50, 16'sh8000, 0, 0, 0, 0, 100);
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9);
    send_fields(1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 9);
    // both tracking limits hit on the same cycle
    send_fields(1, 0, 0, 0, 500, 50, 0, 1, 1001, 1, 0, 200);
    // terminal block while status says goal reached: tracking keeps its latch
    send_fields(1, 1, 0, 1, 32767, 0, 0, 0, 0, 0, 0, 0);
    send_fields(1, 1, 1, 1, -1, -1, -1, 1, 16'hFFFF, 1, 16'hFFFF, 20'hFFFFF);
    send_fields(1, 0, 0, 0, 32767, 32767, 32767, 1, 16'hFFFF, 1, 16'hFFFF, 20'd1000000);
    send_fields(1, 1, 0, 0, 16'sh8000, 0, 0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // guarded distance takes precedence over a raw one
    send_fields(1, 0, 0, 0, 0, 0, 0, 1, 10, 1, 60000, 50);
    send_fields(1, 0, 0, 0, 0, 0, 0, 0, 10, 0, 60000, 50);
    sender_park();
    wait_drained();

    // random scenario bursts, one limit setting per phase
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) c = '0;
      else if (ph == 1) c = '1;
      else c = rand_config(ph % 3 == 0);
      load_limits(c);
      n = 0;
      while (n < PHASE_ITEMS) begin
        sc  = pick_scenario();
        len = $urandom_range(1, 24);
        no_idle = one_in(5);
        if (n == 0 && (ph == 3 || ph == 7)) begin
          // stall the result side while inputs keep coming
          no_idle      = 1'b1;
          hold_off_req = 1'b1;
        end
        for (int unsigned k = 0; k < len && n < PHASE_ITEMS; k++) begin
          send_item(make_item(sc));
          n++;
        end
      end
      no_idle = 1'b0;
      sender_park();
      wait_drained();
    end
    repeat (6) @(posedge clk);

    $display("ran %0d control cycles over %0d limit settings, %0d long result stalls",
             items_sent, config_sets, hold_offs);
    $display("interventions none/terminal/projection/spin %0d/%0d/%0d/%0d, %0d saturated",
             board.intv_count[msv_pkg::INTV_NONE], board.intv_count[msv_pkg::INTV_TERMINAL],
             board.intv_count[msv_pkg::INTV_PROJECTION], board.intv_count[msv_pkg::INTV_SPIN],
             board.saturated_results);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/msv_pkg.sv
src/msv_ifs.sv
src/msv_cfg_regs.sv
src/msv_step_logic.sv
src/motion_safety_supervisor_top.sv
bench/motion_safety_supervisor_top_tb.sv
